[rtl/hblank_vram_dma_controller_macros.svh]
// assertion macros used by the port-level dma controller checker
`ifndef HBLANK_VRAM_DMA_CONTROLLER_MACROS_SVH
`define HBLANK_VRAM_DMA_CONTROLLER_MACROS_SVH

// same-cycle implication, disabled during reset
`define HVDMA_CHK_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hvdma check failed");

// next-cycle implication, disabled during reset
`define HVDMA_CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hvdma check failed");

`endif

[rtl/hvdma_pkg.sv]
// shared types and constants of the video-memory dma controller
package hvdma_pkg;

    // operation kinds of an input transfer
    localparam logic [1:0] KIND_SRC   = 2'd0;
    localparam logic [1:0] KIND_DST   = 2'd1;
    localparam logic [1:0] KIND_CTL   = 2'd2;
    localparam logic [1:0] KIND_BLANK = 2'd3;

    localparam logic [11:0] BLOCK_BYTES   = 12'h010;
    localparam logic [15:0] PTR_STEP      = 16'h0010;
    localparam logic [15:0] SRC_MASK      = 16'hFFF0;
    localparam logic [15:0] DST_MASK      = 16'h1FF0;
    localparam logic [15:0] VRAM_BASE     = 16'h8000;
    localparam logic [15:0] VRAM_END      = 16'hA000;
    localparam logic [7:0]  STATUS_DONE   = 8'hFF;
    localparam logic [13:0] BLANK_CYC     = 14'd36;
    localparam logic [13:0] BLANK_CYC_DS  = 14'd68;
    localparam logic [13:0] GEN_BASE      = 14'd4;
    localparam logic [13:0] GEN_BASE_DS   = 14'd8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // classified command passed from front to back
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
        logic        hblank;
        logic        blank_sel;
        logic [6:0]  count;
        logic [7:0]  blocks;
        logic [11:0] new_bytes;
    } cmd_t;

    // one result item
    typedef struct packed {
        logic        copy_issued;
        logic [15:0] copy_source;
        logic [15:0] copy_dest;
        logic [11:0] copy_length;
        logic [13:0] cycles_charged;
        logic [7:0]  status_out;
        logic        active_out;
        logic [15:0] source_readback;
        logic [15:0] dest_readback;
    } result_t;

endpackage

[rtl/hvdma_front.sv]
// front stage: accepts input transfers and classifies them into commands
module hvdma_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [1:0]         s_tuser,
    input  logic [23:0]        s_tdata,
    output logic               push,
    output hvdma_pkg::cmd_t    push_cmd,
    input  logic               queue_full
);

    logic            valid_reg;
    logic            valid_next;
    hvdma_pkg::cmd_t cmd_reg;
    hvdma_pkg::cmd_t cmd_next;

    // hand the held command to the queue when it has room
    assign push     = valid_reg && !queue_full;
    assign s_tready = !valid_reg || !queue_full;
    assign push_cmd = cmd_reg;

    // decode the incoming transfer
    always_comb begin
        cmd_next.kind      = s_tuser;
        cmd_next.value     = s_tdata[15:0];
        cmd_next.hblank    = s_tdata[16];
        cmd_next.blank_sel = s_tdata[7];
        cmd_next.count     = s_tdata[6:0];
        cmd_next.blocks    = {1'b0, s_tdata[6:0]} + 8'd1;
        cmd_next.new_bytes = {cmd_next.blocks, 4'b0000};
    end

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (push) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

[rtl/hvdma_queue.sv]
// short command queue between front and back
module hvdma_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  hvdma_pkg::cmd_t    push_cmd,
    output logic               full,
    input  logic               pop,
    output logic               pop_valid,
    output hvdma_pkg::cmd_t    pop_cmd
);

    localparam int AW = hvdma_pkg::QUEUE_AW;
    localparam int CW = AW + 1;

    hvdma_pkg::cmd_t entry_reg [hvdma_pkg::QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign full      = (count_reg == CW'(hvdma_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(hvdma_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
        end
        if (pop && pop_valid) begin
            rd_ptr_next = (rd_ptr_reg == AW'(hvdma_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
        end
        if (push && !(pop && pop_valid)) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop && pop_valid) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/hvdma_back.sv]
// back stage: holds the dma state, executes commands, registers the result
module hvdma_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               double_speed,
    input  logic               cmd_valid,
    input  hvdma_pkg::cmd_t    cmd,
    output logic               cmd_pop,
    output logic               res_valid,
    input  logic               res_ready,
    output hvdma_pkg::result_t res
);

    logic [15:0] src_reg,  src_next;
    logic [15:0] dst_reg,  dst_next;
    logic [11:0] bytes_reg, bytes_next;
    logic [7:0]  status_reg, status_next;
    logic        active_reg, active_next;
    logic [15:0] src_mir_reg, src_mir_next;
    logic [15:0] dst_mir_reg, dst_mir_next;
    logic        valid_reg, valid_next;
    hvdma_pkg::result_t res_reg, res_next;

    logic [11:0] bytes_eff;
    logic [7:0]  status_eff;
    logic [15:0] blk_src_add, blk_src;
    logic [15:0] blk_dst_add, blk_dst;
    logic [11:0] blk_bytes;
    logic [7:0]  blk_status;
    logic        blk_active;
    logic [13:0] blk_cycles;
    logic [13:0] gen_cycles;
    logic        do_blank;

    // take a command when the result register is free or being drained
    assign cmd_pop   = cmd_valid && (!valid_reg || res_ready);
    assign res_valid = valid_reg;
    assign res       = res_reg;

    // count and status a blanking block starts from
    always_comb begin
        if (cmd.kind == hvdma_pkg::KIND_CTL) begin
            bytes_eff  = cmd.new_bytes;
            status_eff = {1'b0, cmd.count};
        end else begin
            bytes_eff  = bytes_reg;
            status_eff = status_reg;
        end
    end

    // one 16-byte blanking block with address wrap
    always_comb begin
        blk_src_add = src_reg + hvdma_pkg::PTR_STEP;
        blk_dst_add = dst_reg + hvdma_pkg::PTR_STEP;
        blk_src     = (blk_src_add == hvdma_pkg::VRAM_BASE) ? hvdma_pkg::VRAM_END : blk_src_add;
        blk_dst     = (blk_dst_add == hvdma_pkg::VRAM_END) ? hvdma_pkg::VRAM_BASE : blk_dst_add;
        blk_bytes   = bytes_eff - hvdma_pkg::BLOCK_BYTES;
        blk_status  = status_eff - 8'd1;
        blk_active  = !((blk_status == hvdma_pkg::STATUS_DONE) || (blk_bytes == 12'd0));
        blk_cycles  = double_speed ? hvdma_pkg::BLANK_CYC_DS : hvdma_pkg::BLANK_CYC;
    end

    // general transfer charge
    always_comb begin
        if (double_speed) begin
            gen_cycles = hvdma_pkg::GEN_BASE_DS + {cmd.blocks, 6'b000000};
        end else begin
            gen_cycles = hvdma_pkg::GEN_BASE + {1'b0, cmd.blocks, 5'b00000};
        end
    end

    // command execution
    always_comb begin
        src_next     = src_reg;
        dst_next     = dst_reg;
        bytes_next   = bytes_reg;
        status_next  = status_reg;
        active_next  = active_reg;
        src_mir_next = src_mir_reg;
        dst_mir_next = dst_mir_reg;
        do_blank     = 1'b0;
        res_next     = '0;

        case (cmd.kind)
            hvdma_pkg::KIND_SRC: begin
                src_next     = cmd.value;
                src_mir_next = cmd.value;
            end
            hvdma_pkg::KIND_DST: begin
                dst_next     = cmd.value;
                dst_mir_next = cmd.value;
            end
            hvdma_pkg::KIND_CTL: begin
                bytes_next = cmd.new_bytes;
                if (active_reg) begin
                    if (cmd.blank_sel) begin
                        status_next = {1'b0, cmd.count};
                    end else begin
                        status_next = hvdma_pkg::STATUS_DONE;
                        active_next = 1'b0;
                    end
                end else if (cmd.blank_sel) begin
                    active_next = 1'b1;
                    status_next = {1'b0, cmd.count};
                    do_blank    = cmd.hblank;
                end else begin
                    // general transfer of the whole length at once
                    res_next.copy_issued    = 1'b1;
                    res_next.copy_source    = src_reg & hvdma_pkg::SRC_MASK;
                    res_next.copy_dest      = (dst_reg & hvdma_pkg::DST_MASK)
                                              | hvdma_pkg::VRAM_BASE;
                    res_next.copy_length    = cmd.new_bytes;
                    res_next.cycles_charged = gen_cycles;
                    src_mir_next            = 16'hFFFF;
                    dst_mir_next            = 16'hFFFF;
                    status_next             = hvdma_pkg::STATUS_DONE;
                    src_next                = src_reg + {4'b0000, cmd.new_bytes};
                    dst_next                = dst_reg + {4'b0000, cmd.new_bytes};
                end
            end
            hvdma_pkg::KIND_BLANK: begin
                do_blank = active_reg;
            end
            default: begin
            end
        endcase

        if (do_blank) begin
            res_next.copy_issued    = 1'b1;
            res_next.copy_source    = src_reg;
            res_next.copy_dest      = dst_reg | hvdma_pkg::VRAM_BASE;
            res_next.copy_length    = hvdma_pkg::BLOCK_BYTES;
            res_next.cycles_charged = blk_cycles;
            src_next                = blk_src;
            dst_next                = blk_dst;
            src_mir_next            = blk_src;
            dst_mir_next            = blk_dst;
            bytes_next              = blk_bytes;
            status_next             = blk_status;
            active_next             = blk_active;
        end

        res_next.status_out      = status_next;
        res_next.active_out      = active_next;
        res_next.source_readback = src_mir_next;
        res_next.dest_readback   = dst_mir_next;
    end

    // result register valid
    always_comb begin
        valid_next = valid_reg;
        if (cmd_pop) begin
            valid_next = 1'b1;
        end else if (res_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_reg     <= '0;
            dst_reg     <= '0;
            bytes_reg   <= '0;
            status_reg  <= hvdma_pkg::STATUS_DONE;
            active_reg  <= 1'b0;
            src_mir_reg <= '0;
            dst_mir_reg <= '0;
            valid_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (cmd_pop) begin
                src_reg     <= src_next;
                dst_reg     <= dst_next;
                bytes_reg   <= bytes_next;
                status_reg  <= status_next;
                active_reg  <= active_next;
                src_mir_reg <= src_mir_next;
                dst_mir_reg <= dst_mir_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            res_reg <= res_next;
        end
    end

endmodule

[rtl/hblank_vram_dma_controller.sv]
// top level of the video-memory dma controller
// Usage:
//   s_ channel: one transfer per register write or blanking event; s_tuser
//   holds op (source, destination, control, blanking event), s_tdata holds
//   value and in_hblank. Every accepted transfer yields exactly one m_
//   transfer: m_tuser is copy_issued, m_tdata carries the copy command
//   (all zero without a copy), the cycle charge, status, armed flag and the
//   pointer readbacks.
//   cfg channel: writes double_speed; always ready, write only while idle.
//   The s_ to m_ path runs through the front register, the two-entry
//   command queue and the back result register. Throughput is one item
//   per cycle while m_tready is high, set by the back stage's execute step.
//   Reset (aresetn low, synchronous) clears pointers, count and mirrors,
//   sets status to 0xFF, disarms and empties the queue; no clearing pass.
//   When m_tready is low the result holds, the queue fills, and s_tready
//   drops only once the front register and both queue entries are full.
module hblank_vram_dma_controller (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,    // op
    input  logic [23:0]  s_tdata,    // value, in_hblank, zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [0:0]   m_tuser,    // copy_issued
    output logic [103:0] m_tdata,    // copy_source, copy_dest, copy_length, cycles_charged,
                                     // status_out, active_out, source_readback,
                                     // dest_readback, zero pad
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_data    // double_speed
);

    logic               double_speed_reg;
    logic               push;
    hvdma_pkg::cmd_t    push_cmd;
    logic               queue_full;
    logic               pop;
    logic               pop_valid;
    hvdma_pkg::cmd_t    pop_cmd;
    hvdma_pkg::result_t res;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            double_speed_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            double_speed_reg <= cfg_data[0];
        end
    end

    hvdma_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .push       (push),
        .push_cmd   (push_cmd),
        .queue_full (queue_full)
    );

    hvdma_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd)
    );

    hvdma_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .double_speed (double_speed_reg),
        .cmd_valid    (pop_valid),
        .cmd          (pop_cmd),
        .cmd_pop      (pop),
        .res_valid    (m_tvalid),
        .res_ready    (m_tready),
        .res          (res)
    );

    // result packing
    assign m_tuser = res.copy_issued;
    assign m_tdata = {5'b00000,
                      res.dest_readback,
                      res.source_readback,
                      res.active_out,
                      res.status_out,
                      res.cycles_charged,
                      res.copy_length,
                      res.copy_dest,
                      res.copy_source};

endmodule

[rtl/hvdma_checker.sv]
// port-level checker of the dma controller and its bind
`include "hblank_vram_dma_controller_macros.svh"

module hvdma_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [0:0]   m_tuser,
    input logic [103:0] m_tdata
);

    // a stalled result stays offered
    `HVDMA_CHK_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

    // no copy means an all-zero command and no charge
    `HVDMA_CHK_SAME(a_no_copy_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata[57:0] == 58'd0)

    // every copy goes into video memory and moves at least one block
    `HVDMA_CHK_SAME(a_copy_shape, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[31] && (m_tdata[43:32] != 12'd0))

    // an armed transfer never reports the done status
    `HVDMA_CHK_SAME(a_armed_status, aclk, aresetn, m_tvalid && m_tdata[66], m_tdata[65:58] != 8'hFF)

endmodule

bind hblank_vram_dma_controller hvdma_checker u_hvdma_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
);

[bench/dma_result_checker.sv]
// result checker for the video-memory dma controller: predicts each transfer and compares
module dma_result_checker
    import hvdma_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [1:0]   s_tuser,    // op
    input  logic [23:0]  s_tdata,    // value, in_hblank, zero pad
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [0:0]   m_tuser,    // copy_issued
    input  logic [103:0] m_tdata,    // copy_source, copy_dest, copy_length, cycles_charged,
                                     // status_out, active_out, source_readback,
                                     // dest_readback, zero pad
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [0:0]   cfg_data,   // double_speed
    output int           fail_count,
    output int           pending
);

    localparam int          NUM_FIELDS  = 9;
    localparam int          PRINT_CAP   = 40;
    localparam logic [15:0] MIRROR_DONE = 16'hFFFF;

    // predicted controller state
    logic        speed_mode;
    logic [15:0] src_ptr;
    logic [15:0] dst_ptr;
    logic [11:0] bytes_left;
    logic [7:0]  status;
    logic        armed;
    logic [15:0] src_mirror;
    logic [15:0] dst_mirror;

    result_t expected_results[$];
    int      failures = 0;

    // one line per mismatch, printing capped, counting not
    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        if (failures < PRINT_CAP)
            $display("dma mismatch: %s got %h expected %h", what, got, want);
        failures++;
    endtask

    function automatic string field_name(int idx);
        case (idx)
            0: return "copy_issued";
            1: return "copy_source";
            2: return "copy_dest";
            3: return "copy_length";
            4: return "cycles_charged";
            5: return "status_out";
            6: return "active_out";
            7: return "source_readback";
            default: return "dest_readback";
        endcase
    endfunction

    function automatic logic [15:0] field_of(result_t r, int idx);
        case (idx)
            0: return 16'(r.copy_issued);
            1: return r.copy_source;
            2: return r.copy_dest;
            3: return 16'(r.copy_length);
            4: return 16'(r.cycles_charged);
            5: return 16'(r.status_out);
            6: return 16'(r.active_out);
            7: return r.source_readback;
            default: return r.dest_readback;
        endcase
    endfunction

    // one 16-byte blanking block with the video-memory wrap rules
    task automatic copy_blank_block(inout result_t r);
        r.copy_issued = 1'b1;
        r.copy_source = src_ptr;
        r.copy_dest   = dst_ptr | VRAM_BASE;
        r.copy_length = BLOCK_BYTES;
        src_ptr = src_ptr + PTR_STEP;
        dst_ptr = dst_ptr + PTR_STEP;
        if (dst_ptr == VRAM_END)
            dst_ptr = VRAM_BASE;
        if (src_ptr == VRAM_BASE)
            src_ptr = VRAM_END;
        src_mirror = src_ptr;
        dst_mirror = dst_ptr;
        bytes_left = bytes_left - BLOCK_BYTES;
        status     = status - 8'd1;
        if (status == STATUS_DONE || bytes_left == 12'd0)
            armed = 1'b0;
        r.cycles_charged = speed_mode ? BLANK_CYC_DS : BLANK_CYC;
    endtask

    // apply one input transfer to the state and build its result
    task automatic advance_dma_state(logic [1:0] op, logic [15:0] value, logic hblank,
                                     output result_t r);
        logic [7:0] ctl;
        int         blocks;
        r = '0;
        case (op)
            KIND_SRC: begin
                src_ptr    = value;
                src_mirror = value;
            end
            KIND_DST: begin
                dst_ptr    = value;
                dst_mirror = value;
            end
            KIND_CTL: begin
                ctl        = value[7:0];
                blocks     = int'(ctl[6:0]) + 1;
                bytes_left = 12'(blocks * 16);
                if (armed) begin
                    if (ctl[7]) begin
                        status = {1'b0, ctl[6:0]};
                    end else begin
                        status = STATUS_DONE;
                        armed  = 1'b0;
                    end
                end else if (ctl[7]) begin
                    armed  = 1'b1;
                    status = {1'b0, ctl[6:0]};
                    if (hblank)
                        copy_blank_block(r);
                end else begin
                    // general transfer of the whole length at once
                    r.copy_issued = 1'b1;
                    r.copy_source = src_ptr & SRC_MASK;
                    r.copy_dest   = (dst_ptr & DST_MASK) | VRAM_BASE;
                    r.copy_length = bytes_left;
                    src_mirror = MIRROR_DONE;
                    dst_mirror = MIRROR_DONE;
                    status     = STATUS_DONE;
                    src_ptr    = src_ptr + {4'd0, bytes_left};
                    dst_ptr    = dst_ptr + {4'd0, bytes_left};
                    r.cycles_charged = speed_mode ? 14'(4 * (2 + 16 * blocks))
                                                  : 14'(4 * (1 + 8 * blocks));
                end
            end
            default: begin
                if (armed)
                    copy_blank_block(r);
            end
        endcase
        r.status_out      = status;
        r.active_out      = armed;
        r.source_readback = src_mirror;
        r.dest_readback   = dst_mirror;
    endtask

    // watch all three channels at each edge
    always @(posedge aclk) begin : watch
        result_t got;
        result_t want;
        if (!aresetn) begin
            speed_mode = 1'b0;
            src_ptr    = '0;
            dst_ptr    = '0;
            bytes_left = '0;
            status     = STATUS_DONE;
            armed      = 1'b0;
            src_mirror = '0;
            dst_mirror = '0;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                speed_mode = cfg_data[0];
            // results first, so a result never meets its own input's prediction
            if (m_tvalid && m_tready) begin
                got.copy_issued     = m_tuser[0];
                got.copy_source     = m_tdata[15:0];
                got.copy_dest       = m_tdata[31:16];
                got.copy_length     = m_tdata[43:32];
                got.cycles_charged  = m_tdata[57:44];
                got.status_out      = m_tdata[65:58];
                got.active_out      = m_tdata[66];
                got.source_readback = m_tdata[82:67];
                got.dest_readback   = m_tdata[98:83];
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing pending, copy_source",
                                    got.copy_source, 16'd0);
                end else begin
                    want = expected_results.pop_front();
                    for (int i = 0; i < NUM_FIELDS; i++)
                        if (field_of(got, i) !== field_of(want, i))
                            report_mismatch(field_name(i), field_of(got, i), field_of(want, i));
                end
            end
            if (s_tvalid && s_tready) begin
                advance_dma_state(s_tuser, s_tdata[15:0], s_tdata[16], want);
                expected_results.push_back(want);
            end
        end
        fail_count <= failures;
        pending    <= expected_results.size();
    end

endmodule

[bench/tb_top.sv]
// testbench top for the video-memory dma controller: stimulus, stalls and verdict
module tb_top;
    import hvdma_pkg::*;

    localparam int HOLD_CYCLES  = 60;
    localparam int STUCK_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;

    typedef enum int {PRESS_NONE, PRESS_HOLD, PRESS_PAUSE} pressure_t;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [1:0]   s_tuser;     // op
    logic [23:0]  s_tdata;     // value, in_hblank, zero pad
    logic         m_tvalid;
    logic         m_tready;
    logic [0:0]   m_tuser;     // copy_issued
    logic [103:0] m_tdata;     // copy_source, copy_dest, copy_length, cycles_charged,
                               // status_out, active_out, source_readback,
                               // dest_readback, zero pad
    logic         cfg_valid;
    logic         cfg_ready;
    logic [0:0]   cfg_data;    // double_speed

    int fail_count;
    int pending_results;
    int items_sent    = 0;
    int stuck_cycles  = 0;
    bit idle_on       = 1'b1;
    bit hold_request  = 1'b0;

    hblank_vram_dma_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    dma_result_checker result_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tuser    (m_tuser),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending_results)
    );

    // clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                stuck_cycles <= 0;
            end else if (stuck_cycles >= STUCK_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        wait (aresetn === 1'b1);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // one input transfer, with an optional gap ahead of it
    task automatic push_item(logic [1:0] op, logic [15:0] value, logic hblank, bit counted);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, hblank, value};
        do @(posedge aclk); while (!s_tready);
        if (counted)
            items_sent++;
    endtask

    // stop offering and wait until every expected result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
    endtask

    task automatic write_speed_mode(logic mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // pointers biased toward the wrap points of the blanking copy
    function automatic logic [15:0] pick_ptr();
        case ($urandom_range(0, 9))
            0: return 16'h7FF0 - 16'($urandom_range(0, 3) * 16);
            1: return 16'h9FF0 - 16'($urandom_range(0, 3) * 16);
            2: return 16'hFFF0 | 16'($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    // one episode: armed blanking run, general transfer, or noise
    task automatic run_episode();
        int kind;
        int count;
        int nblank;
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            push_item(KIND_SRC, pick_ptr(), 1'($urandom), 1'b1);
            if ($urandom_range(0, 3) != 0)
                push_item(KIND_DST, pick_ptr(), 1'($urandom), 1'b1);
            count = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 7);
            push_item(KIND_CTL, {8'($urandom), 1'b1, 7'(count)}, 1'($urandom), 1'b1);
            nblank = (count < 12) ? count + 1 : 12;
            repeat (nblank) begin
                if ($urandom_range(0, 15) == 0)
                    push_item(KIND_CTL, 16'($urandom), 1'($urandom), 1'b1);
                push_item(KIND_BLANK, 16'($urandom), 1'($urandom), 1'b1);
            end
            // cancel a long run now and then, otherwise it carries over
            if (count >= 12 && $urandom_range(0, 1) == 1)
                push_item(KIND_CTL, {8'($urandom), 1'b0, 7'($urandom)}, 1'($urandom), 1'b1);
            if ($urandom_range(0, 1) == 1)
                push_item(KIND_BLANK, 16'($urandom), 1'($urandom), 1'b0);
        end else if (kind < 8) begin
            push_item(KIND_SRC, pick_ptr(), 1'($urandom), 1'b1);
            push_item(KIND_DST, pick_ptr(), 1'($urandom), 1'b1);
            push_item(KIND_CTL, {8'($urandom), 1'b0, 7'($urandom)}, 1'($urandom), 1'b1);
        end else begin
            repeat ($urandom_range(1, 3))
                push_item(2'($urandom), 16'($urandom), 1'($urandom), 1'b1);
        end
    endtask

    task automatic run_random_phase(int target, pressure_t mode);
        int  start;
        bit  pressed;
        start   = items_sent;
        pressed = 1'b0;
        while (items_sent - start < target) begin
            if (!pressed && items_sent - start >= target / 3) begin
                pressed = 1'b1;
                if (mode == PRESS_HOLD)
                    hold_request = 1'b1;
                else if (mode == PRESS_PAUSE)
                    wait_drained();
            end
            run_episode();
        end
    endtask

    // main sequence
    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = KIND_SRC;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_speed_mode(1'b0);

        // general transfer from the top of memory, pointers wrap
        push_item(KIND_SRC, 16'hFFFF, 1'b0, 1'b1);
        push_item(KIND_DST, 16'h0000, 1'b1, 1'b1);
        push_item(KIND_CTL, 16'h0000, 1'b0, 1'b1);
        // arm in blanking: both pointers hit their wrap, single block ends the run
        push_item(KIND_SRC, 16'h7FF0, 1'b0, 1'b1);
        push_item(KIND_DST, 16'h9FF0, 1'b0, 1'b1);
        push_item(KIND_CTL, 16'h0080, 1'b1, 1'b1);
        // blanking event while disarmed is ignored
        push_item(KIND_BLANK, 16'hFFFF, 1'b1, 1'b1);
        // three-block run to completion, then one more ignored event
        push_item(KIND_CTL, 16'h0082, 1'b0, 1'b1);
        push_item(KIND_BLANK, 16'h0000, 1'b0, 1'b1);
        push_item(KIND_BLANK, 16'h0000, 1'b1, 1'b1);
        push_item(KIND_BLANK, 16'h5555, 1'b0, 1'b1);
        push_item(KIND_BLANK, 16'hAAAA, 1'b0, 1'b1);
        // restart an armed run at the largest count, then cancel it
        push_item(KIND_CTL, 16'h0085, 1'b0, 1'b1);
        push_item(KIND_CTL, 16'h00FF, 1'b1, 1'b1);
        push_item(KIND_BLANK, 16'h0000, 1'b0, 1'b1);
        push_item(KIND_CTL, 16'h0000, 1'b1, 1'b1);
        // largest general transfer with upper control bits set
        push_item(KIND_SRC, 16'h0000, 1'b1, 1'b1);
        push_item(KIND_DST, 16'hFFFF, 1'b0, 1'b1);
        push_item(KIND_CTL, 16'hFF7F, 1'b0, 1'b1);
        // arm with every control bit set while in blanking
        push_item(KIND_CTL, 16'hFFFF, 1'b1, 1'b1);
        push_item(KIND_BLANK, 16'hFFFF, 1'b1, 1'b1);
        wait_drained();

        write_speed_mode(1'b1);
        run_random_phase(170, PRESS_HOLD);
        wait_drained();

        write_speed_mode(1'b0);
        run_random_phase(170, PRESS_PAUSE);
        wait_drained();

        // last stretch at full rate on both sides
        idle_on = 1'b0;
        write_speed_mode(1'b1);
        run_random_phase(150, PRESS_NONE);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending_results == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
